// ----- rtl/basic_source_tokenizer_assert.svh -----
// Assertion macros shared by the tokenizer RTL
`ifndef BASIC_SOURCE_TOKENIZER_ASSERT_SVH
`define BASIC_SOURCE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define BST_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tokenizer check failed");
`define BST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define BST_ASSERT(lbl, clk, rst, prop)
`define BST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/bst_pkg.sv -----
// Shared types and constants for the source tokenizer
`default_nettype none

package bst_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int FIELD_W      = 16;
  localparam int RES_MAX      = 3;

  typedef enum logic [2:0] {
    K_NEWLINE = 3'd0,
    K_STRING  = 3'd1,
    K_HEX     = 3'd2,
    K_INTEGER = 3'd3,
    K_REAL    = 3'd4,
    K_IDENT   = 3'd5,
    K_PUNCT   = 3'd6,
    K_END     = 3'd7
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] column;
    logic               last;
  } tok_rec_t;

  // Results of one source byte: close of the running token, a one-char
  // token or flushed token, and the end token, in emission order.
  typedef struct packed {
    logic [RES_MAX-1:0]     vld;
    tok_rec_t [RES_MAX-1:0] rec;
  } tok_push_t;

endpackage

`default_nettype wire

// ----- rtl/bst_lex.sv -----
// Lexer state and per-byte next-state / token logic
`default_nettype none
`include "basic_source_tokenizer_assert.svh"

module bst_lex #(
  parameter int POS_BITS = bst_pkg::POS_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_en,
  input  wire bst_pkg::src_item_t item,
  output bst_pkg::tok_push_t     push
);
  import bst_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_STR   = 4'd1,
    M_PEND  = 4'd2,
    M_HEX   = 4'd3,
    M_INT   = 4'd4,
    M_INTR  = 4'd5,
    M_FRAC  = 4'd6,
    M_EXPS  = 4'd7,
    M_EXPD  = 4'd8,
    M_IDENT = 4'd9
  } mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (&v) ? v : v + POS_ONE;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_UPPER_E) || (c == CH_LOWER_E);
  endfunction

  function automatic tok_rec_t mk_rec(input tok_kind_t k, input logic [POS_BITS-1:0] off,
                                      input logic [POS_BITS-1:0] len,
                                      input logic [POS_BITS-1:0] ln,
                                      input logic [POS_BITS-1:0] col, input logic lst);
    tok_rec_t r;
    r.kind   = k;
    r.offset = FIELD_W'(off);
    r.length = FIELD_W'(len);
    r.line   = FIELD_W'(ln);
    r.column = FIELD_W'(col);
    r.last   = lst;
    return r;
  endfunction

  // state
  mode_t               mode;
  logic [7:0]          pend;
  logic [POS_BITS-1:0] ts_off, ts_line, ts_col, tlen;
  logic [POS_BITS-1:0] cur_off, cur_line, cur_col;

  // after the byte, before end-of-source handling
  mode_t               mode_f, mode_next;
  logic [7:0]          pend_f, pend_next;
  logic [POS_BITS-1:0] ts_off_f, ts_line_f, ts_col_f, tlen_f;
  logic [POS_BITS-1:0] cur_off_f, cur_line_f, cur_col_f;
  logic [POS_BITS-1:0] ts_off_next, ts_line_next, ts_col_next, tlen_next;
  logic [POS_BITS-1:0] cur_off_next, cur_line_next, cur_col_next;

  logic [7:0]          c;
  logic                grow, close, do_idle;
  tok_kind_t           close_kind;
  logic [POS_BITS-1:0] tlen_inc, close_len;

  logic                ic_skip, ic_nl, ic_begin, ic_punct;
  mode_t               ic_mode;

  logic                single_v, flush_v, end_v, close_v;
  tok_kind_t           flush_kind;
  logic [2:0]          last_bits;

  assign c        = item.ch;
  assign tlen_inc = sat_inc(tlen);

  // class of a byte seen while no token is open
  always_comb begin
    ic_skip = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    ic_nl   = (c == CH_NL);
    priority if (c == CH_QUOTE) begin
      ic_mode = M_STR;
    end else if ((c == CH_DOLLAR) || (c == CH_DOT) || (c == CH_COLON) ||
                 (c == CH_LT) || (c == CH_GT)) begin
      ic_mode = M_PEND;
    end else if (is_digit(c)) begin
      ic_mode = M_INT;
    end else if (is_alpha(c)) begin
      ic_mode = M_IDENT;
    end else begin
      ic_mode = M_IDLE;
    end
    ic_begin = !ic_skip && !ic_nl;
    ic_punct = ic_begin && (ic_mode == M_IDLE);
  end

  always_comb begin
    grow       = 1'b0;
    close      = 1'b0;
    do_idle    = 1'b0;
    close_kind = K_PUNCT;
    mode_f     = mode;
    if (item.has_char) begin
      unique case (mode)
        M_STR: begin
          if (c == CH_QUOTE) begin
            grow = 1'b1; close = 1'b1; close_kind = K_STRING;
          end else if (c == CH_NL) begin
            close = 1'b1; close_kind = K_STRING; do_idle = 1'b1;
          end else begin
            grow = 1'b1;
          end
        end
        M_PEND: begin
          if ((pend == CH_DOLLAR) && is_xdigit(c)) begin
            grow = 1'b1; mode_f = M_HEX;
          end else if ((pend == CH_DOT) && is_digit(c)) begin
            grow = 1'b1; mode_f = M_INTR;
          end else if (((pend == CH_COLON) && (c == CH_EQ)) ||
                       ((pend == CH_LT) && ((c == CH_GT) || (c == CH_EQ))) ||
                       ((pend == CH_GT) && (c == CH_EQ))) begin
            grow = 1'b1; close = 1'b1; close_kind = K_PUNCT;
          end else begin
            close = 1'b1; close_kind = K_PUNCT; do_idle = 1'b1;
          end
        end
        M_HEX: begin
          if (is_xdigit(c)) begin
            grow = 1'b1;
          end else begin
            close = 1'b1; close_kind = K_HEX; do_idle = 1'b1;
          end
        end
        M_INT, M_INTR: begin
          if (is_digit(c)) begin
            grow = 1'b1;
          end else if (c == CH_DOT) begin
            grow = 1'b1; mode_f = M_FRAC;
          end else if (is_exp(c)) begin
            grow = 1'b1; mode_f = M_EXPS;
          end else begin
            close = 1'b1; do_idle = 1'b1;
            close_kind = (mode == M_INT) ? K_INTEGER : K_REAL;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            grow = 1'b1;
          end else if (is_exp(c)) begin
            grow = 1'b1; mode_f = M_EXPS;
          end else begin
            close = 1'b1; close_kind = K_REAL; do_idle = 1'b1;
          end
        end
        M_EXPS: begin
          if ((c == CH_PLUS) || (c == CH_MINUS) || is_digit(c)) begin
            grow = 1'b1; mode_f = M_EXPD;
          end else begin
            close = 1'b1; close_kind = K_REAL; do_idle = 1'b1;
          end
        end
        M_EXPD: begin
          if (is_digit(c)) begin
            grow = 1'b1;
          end else begin
            close = 1'b1; close_kind = K_REAL; do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_digit(c) || is_alpha(c) || (c == CH_USCORE) || (c == CH_DOLLAR)) begin
            grow = 1'b1;
          end else begin
            close = 1'b1; close_kind = K_IDENT; do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    close_len = grow ? tlen_inc : tlen;
    tlen_f    = close_len;
    ts_off_f  = ts_off;
    ts_line_f = ts_line;
    ts_col_f  = ts_col;
    pend_f    = pend;
    if (close) begin
      mode_f = M_IDLE;
    end
    if (do_idle) begin
      mode_f = M_IDLE;
      if (ic_begin) begin
        mode_f    = ic_mode;
        ts_off_f  = cur_off;
        ts_line_f = cur_line;
        ts_col_f  = cur_col;
        tlen_f    = POS_ONE;
        if (ic_mode == M_PEND) begin
          pend_f = c;
        end
      end
    end

    cur_off_f  = cur_off;
    cur_line_f = cur_line;
    cur_col_f  = cur_col;
    if (item.has_char) begin
      cur_off_f = sat_inc(cur_off);
      if (c == CH_NL) begin
        cur_line_f = sat_inc(cur_line);
        cur_col_f  = POS_ONE;
      end else begin
        cur_col_f = sat_inc(cur_col);
      end
    end

    flush_v    = item.end_of_source;
    flush_kind = K_PUNCT;
    unique case (mode_f)
      M_STR:   flush_kind = K_STRING;
      M_PEND:  flush_kind = K_PUNCT;
      M_HEX:   flush_kind = K_HEX;
      M_INT:   flush_kind = K_INTEGER;
      M_INTR, M_FRAC, M_EXPS, M_EXPD: flush_kind = K_REAL;
      M_IDENT: flush_kind = K_IDENT;
      default: flush_v = 1'b0;
    endcase

    close_v  = close;
    single_v = do_idle && (ic_nl || ic_punct);
    end_v    = item.end_of_source;

    if (item.end_of_source) begin
      mode_next     = M_IDLE;
      pend_next     = '0;
      ts_off_next   = '0;
      ts_line_next  = POS_ONE;
      ts_col_next   = POS_ONE;
      tlen_next     = '0;
      cur_off_next  = '0;
      cur_line_next = POS_ONE;
      cur_col_next  = POS_ONE;
    end else begin
      mode_next     = mode_f;
      pend_next     = pend_f;
      ts_off_next   = ts_off_f;
      ts_line_next  = ts_line_f;
      ts_col_next   = ts_col_f;
      tlen_next     = tlen_f;
      cur_off_next  = cur_off_f;
      cur_line_next = cur_line_f;
      cur_col_next  = cur_col_f;
    end
  end

  // slot 1 carries either the one-char token or the flushed token; never both
  always_comb begin
    push.vld[0] = close_v;
    push.vld[1] = single_v || flush_v;
    push.vld[2] = end_v;
    push.rec[0] = mk_rec(close_kind, ts_off, close_len, ts_line, ts_col,
                         !(single_v || flush_v) && !end_v);
    if (single_v) begin
      push.rec[1] = mk_rec(ic_nl ? K_NEWLINE : K_PUNCT, cur_off, POS_ONE, cur_line, cur_col,
                           !end_v);
    end else begin
      push.rec[1] = mk_rec(flush_kind, ts_off_f, tlen_f, ts_line_f, ts_col_f, !end_v);
    end
    push.rec[2] = mk_rec(K_END, cur_off_f, '0, cur_line_f, cur_col_f, 1'b1);
    last_bits   = {push.vld[2] & push.rec[2].last, push.vld[1] & push.rec[1].last,
                   push.vld[0] & push.rec[0].last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      pend     <= '0;
      ts_off   <= '0;
      ts_line  <= POS_ONE;
      ts_col   <= POS_ONE;
      tlen     <= '0;
      cur_off  <= '0;
      cur_line <= POS_ONE;
      cur_col  <= POS_ONE;
    end else if (step_en) begin
      mode     <= mode_next;
      pend     <= pend_next;
      ts_off   <= ts_off_next;
      ts_line  <= ts_line_next;
      ts_col   <= ts_col_next;
      tlen     <= tlen_next;
      cur_off  <= cur_off_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
    end
  end

  `BST_ASSERT(a_single_or_flush, clk, rst, step_en |-> !(single_v && flush_v))
  `BST_ASSERT(a_one_last, clk, rst, (step_en && (push.vld != '0)) |-> ($countones(last_bits) == 1))
  `BST_ASSERT_NEXT(a_eos_clears, clk, rst, step_en && item.end_of_source, (mode == M_IDLE) && (cur_off == '0) && (cur_line == POS_ONE) && (cur_col == POS_ONE))

endmodule

`default_nettype wire

// ----- rtl/bst_outq.sv -----
// Four-entry result queue between the lexer and the token channel
`default_nettype none
`include "basic_source_tokenizer_assert.svh"

module bst_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_en,
  input  wire bst_pkg::tok_push_t push,
  input  wire logic               tok_stall,
  output logic                    tok_valid,
  output bst_pkg::tok_rec_t       head,
  output logic                    room
);
  import bst_pkg::*;

  localparam int QDEPTH = 4;
  localparam int CW     = $clog2(QDEPTH + 1);

  tok_rec_t          ent [QDEPTH];
  tok_rec_t          ent_next [QDEPTH];
  logic [CW-1:0]     count, count_next, cnt_pop, n_push;
  logic [CW-1:0]     pos [RES_MAX];
  logic              pop;

  assign tok_valid = (count != '0);
  assign head      = ent[0];
  // room for a full request of three results even if nothing drains
  assign room      = (count <= CW'(1));

  always_comb begin
    pop     = tok_valid && !tok_stall;
    cnt_pop = count - CW'(pop);
    n_push  = CW'($countones(push.vld));
    pos[0]  = cnt_pop;
    for (int j = 1; j < RES_MAX; j++) begin
      pos[j] = pos[j-1] + CW'(push.vld[j-1]);
    end
    for (int i = 0; i < QDEPTH - 1; i++) begin
      ent_next[i] = pop ? ent[i+1] : ent[i];
    end
    ent_next[QDEPTH-1] = ent[QDEPTH-1];
    if (push_en) begin
      for (int i = 0; i < QDEPTH; i++) begin
        for (int j = 0; j < RES_MAX; j++) begin
          if (push.vld[j] && (pos[j] == CW'(i))) begin
            ent_next[i] = push.rec[j];
          end
        end
      end
    end
    count_next = cnt_pop + (push_en ? n_push : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      ent[i] <= ent_next[i];
    end
  end

  `BST_ASSERT(a_push_has_room, clk, rst, push_en |-> (count <= CW'(1)))
  `BST_ASSERT(a_depth, clk, rst, count <= CW'(QDEPTH))

endmodule

`default_nettype wire

// ----- rtl/basic_source_tokenizer.sv -----
// Top level of the streaming source tokenizer
`default_nettype none
// Streaming source tokenizer.
// Source channel: one byte per request on ch, with has_char and
// end_of_source; taken when src_valid is high and src_stall is low.
// Token channel: one descriptor per request (kind, start offset, length,
// start line, start column, last); taken when tok_valid is high and
// tok_stall is low. last marks the final token caused by a source byte.
// A byte is held in an input register and handled by the lexer once the
// result queue has room for its tokens; they enter this four-entry queue,
// from which the token channel is served.
// Throughput is one byte per cycle while bytes give at most one token each
// and the receiver does not stall; further tokens of a byte go out one at a
// time, and src_stall is high while a byte waits and over one token is queued.
// A stalled receiver holds the current token; the queue keeps filling until
// that limit, then src_stall rises. Synchronous reset empties the queue and
// input register and returns the lexer to line 1, column 1, offset 0.
// The end-of-source request flushes the open token, adds the end token and
// returns the lexer to its reset state.

module basic_source_tokenizer #(
  parameter int POS_BITS = bst_pkg::POS_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        src_valid,
  output logic                             src_stall,
  input  wire logic [7:0]                  ch,
  input  wire logic                        has_char,
  input  wire logic                        end_of_source,
  output logic                             tok_valid,
  input  wire logic                        tok_stall,
  output logic [2:0]                       token_kind,
  output logic [bst_pkg::FIELD_W-1:0]      start_offset,
  output logic [bst_pkg::FIELD_W-1:0]      token_length,
  output logic [bst_pkg::FIELD_W-1:0]      start_line,
  output logic [bst_pkg::FIELD_W-1:0]      start_column,
  output logic                             last
);
  import bst_pkg::*;

  src_item_t in_q;
  logic      in_vld_q;
  logic      room, step_en, src_take;
  tok_push_t push;
  tok_rec_t  head;

  assign step_en   = in_vld_q && room;
  assign src_stall = in_vld_q && !room;
  assign src_take  = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (!src_stall) begin
      in_vld_q <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      in_q.ch            <= ch;
      in_q.has_char      <= has_char;
      in_q.end_of_source <= end_of_source;
    end
  end

  bst_lex #(
    .POS_BITS (POS_BITS)
  ) u_lex (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (in_q),
    .push    (push)
  );

  bst_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (step_en),
    .push      (push),
    .tok_stall (tok_stall),
    .tok_valid (tok_valid),
    .head      (head),
    .room      (room)
  );

  assign token_kind   = head.kind;
  assign start_offset = head.offset;
  assign token_length = head.length;
  assign start_line   = head.line;
  assign start_column = head.column;
  assign last         = head.last;

endmodule

`default_nettype wire

// ----- test/basic_source_tokenizer_tb.sv -----
// Self-checking testbench for the streaming source tokenizer
`timescale 1ns / 100ps

module basic_source_tokenizer_tb;
  import bst_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTS     = 40;

  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_NL     = 8'h0A;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_DOLLAR = "$";
  localparam logic [7:0] C_DOT    = ".";
  localparam logic [7:0] C_COLON  = ":";
  localparam logic [7:0] C_LT     = "<";
  localparam logic [7:0] C_GT     = ">";
  localparam logic [7:0] C_EQ     = "=";
  localparam logic [7:0] C_UNDER  = "_";
  localparam logic [7:0] C_PLUS   = "+";
  localparam logic [7:0] C_MINUS  = "-";
  localparam logic [7:0] C_EXP_UC = "E";
  localparam logic [7:0] C_EXP_LC = "e";

  typedef enum logic [3:0] {
    LX_IDLE, LX_STR, LX_PEND, LX_HEX, LX_INT, LX_INTR,
    LX_FRAC, LX_EXPS, LX_EXPD, LX_IDENT
  } lex_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [7:0]  ch = 8'h00;
  logic        has_char = 1'b0;
  logic        end_of_source = 1'b0;
  logic        tok_valid;
  logic        tok_stall = 1'b1;
  logic [2:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        last;

  // lexer shadow state
  lex_mode_t   lx_mode;
  logic [7:0]  lx_pend;
  logic [15:0] ts_off, ts_line, ts_col;
  logic [15:0] cur_off, cur_line, cur_col;
  logic [15:0] lx_len;

  tok_rec_t    byte_tokens[$];
  tok_rec_t    want_tokens[$];
  logic [7:0]  src_bytes[$];

  int errors = 0;
  int tokens_seen = 0;
  int stalled_cycles = 0;
  int src_gap_max = 7;
  int sink_stall_max = 7;
  int sink_hold = 0;

  basic_source_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .ch(ch),
    .has_char(has_char),
    .end_of_source(end_of_source),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .token_kind(token_kind),
    .start_offset(start_offset),
    .token_length(token_length),
    .start_line(start_line),
    .start_column(start_column),
    .last(last)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit is_exp(logic [7:0] c);
    return c == C_EXP_UC || c == C_EXP_LC;
  endfunction

  function automatic void lex_reset();
    lx_mode  = LX_IDLE;
    lx_pend  = 8'h00;
    ts_off   = 16'd0;
    ts_line  = 16'd1;
    ts_col   = 16'd1;
    cur_off  = 16'd0;
    cur_line = 16'd1;
    cur_col  = 16'd1;
    lx_len   = 16'd0;
  endfunction

  function automatic void add_tok(tok_kind_t k, logic [15:0] off, logic [15:0] len,
                                  logic [15:0] line, logic [15:0] col);
    tok_rec_t r;
    if (byte_tokens.size() >= RES_MAX) return;
    r.kind   = k;
    r.offset = off;
    r.length = len;
    r.line   = line;
    r.column = col;
    r.last   = 1'b0;
    byte_tokens = {byte_tokens, r};
  endfunction

  function automatic void close_tok(tok_kind_t k);
    add_tok(k, ts_off, lx_len, ts_line, ts_col);
    lx_mode = LX_IDLE;
  endfunction

  function automatic void open_tok(lex_mode_t m);
    lx_mode = m;
    ts_off  = cur_off;
    ts_line = cur_line;
    ts_col  = cur_col;
    lx_len  = 16'd1;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    lx_mode = LX_IDLE;
    if (c == C_SPACE || c == C_TAB || c == C_CR) return;
    if (c == C_NL) begin
      add_tok(K_NEWLINE, cur_off, 16'd1, cur_line, cur_col);
      return;
    end
    if (c == C_QUOTE) begin
      open_tok(LX_STR);
      return;
    end
    // lookahead characters wait for the next byte
    if (c == C_DOLLAR || c == C_DOT || c == C_COLON || c == C_LT || c == C_GT) begin
      open_tok(LX_PEND);
      lx_pend = c;
      return;
    end
    if (is_digit(c)) begin
      open_tok(LX_INT);
      return;
    end
    if (is_alpha(c)) begin
      open_tok(LX_IDENT);
      return;
    end
    open_tok(LX_IDLE);
    close_tok(K_PUNCT);
  endfunction

  function automatic void lex_char(logic [7:0] c);
    case (lx_mode)
      LX_STR: begin
        if (c == C_QUOTE) begin
          lx_len = sat_inc(lx_len);
          close_tok(K_STRING);
        end else if (c == C_NL) begin
          close_tok(K_STRING);
          lex_idle(c);
        end else begin
          lx_len = sat_inc(lx_len);
        end
      end
      LX_PEND: begin
        if (lx_pend == C_DOLLAR && is_hex(c)) begin
          lx_len = sat_inc(lx_len);
          lx_mode = LX_HEX;
        end else if (lx_pend == C_DOT && is_digit(c)) begin
          lx_len = sat_inc(lx_len);
          lx_mode = LX_INTR;
        end else if ((lx_pend == C_COLON && c == C_EQ) ||
                     (lx_pend == C_LT && (c == C_GT || c == C_EQ)) ||
                     (lx_pend == C_GT && c == C_EQ)) begin
          lx_len = sat_inc(lx_len);
          close_tok(K_PUNCT);
        end else begin
          close_tok(K_PUNCT);
          lex_idle(c);
        end
      end
      LX_HEX: begin
        if (is_hex(c)) lx_len = sat_inc(lx_len);
        else begin
          close_tok(K_HEX);
          lex_idle(c);
        end
      end
      LX_INT, LX_INTR: begin
        if (is_digit(c)) lx_len = sat_inc(lx_len);
        else if (c == C_DOT) begin
          lx_len = sat_inc(lx_len);
          lx_mode = LX_FRAC;
        end else if (is_exp(c)) begin
          lx_len = sat_inc(lx_len);
          lx_mode = LX_EXPS;
        end else begin
          close_tok(lx_mode == LX_INT ? K_INTEGER : K_REAL);
          lex_idle(c);
        end
      end
      LX_FRAC: begin
        if (is_digit(c)) lx_len = sat_inc(lx_len);
        else if (is_exp(c)) begin
          lx_len = sat_inc(lx_len);
          lx_mode = LX_EXPS;
        end else begin
          close_tok(K_REAL);
          lex_idle(c);
        end
      end
      LX_EXPS: begin
        if (c == C_PLUS || c == C_MINUS || is_digit(c)) begin
          lx_len = sat_inc(lx_len);
          lx_mode = LX_EXPD;
        end else begin
          close_tok(K_REAL);
          lex_idle(c);
        end
      end
      LX_EXPD: begin
        if (is_digit(c)) lx_len = sat_inc(lx_len);
        else begin
          close_tok(K_REAL);
          lex_idle(c);
        end
      end
      LX_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == C_UNDER || c == C_DOLLAR)
          lx_len = sat_inc(lx_len);
        else begin
          close_tok(K_IDENT);
          lex_idle(c);
        end
      end
      default: lex_idle(c);
    endcase
  endfunction

  function automatic void lex_flush();
    case (lx_mode)
      LX_STR:   close_tok(K_STRING);
      LX_PEND:  close_tok(K_PUNCT);
      LX_HEX:   close_tok(K_HEX);
      LX_INT:   close_tok(K_INTEGER);
      LX_INTR, LX_FRAC, LX_EXPS, LX_EXPD: close_tok(K_REAL);
      LX_IDENT: close_tok(K_IDENT);
      default:  lx_mode = LX_IDLE;
    endcase
  endfunction

  // tokens caused by one accepted request, appended to the expected queue
  function automatic void predict_tokens(logic [7:0] c, logic has, logic eos);
    tok_rec_t r;
    byte_tokens.delete();
    if (has) begin
      lex_char(c);
      cur_off = sat_inc(cur_off);
      if (c == C_NL) begin
        cur_line = sat_inc(cur_line);
        cur_col  = 16'd1;
      end else begin
        cur_col = sat_inc(cur_col);
      end
    end
    if (eos) begin
      lex_flush();
      add_tok(K_END, cur_off, 16'd0, cur_line, cur_col);
      lex_reset();
    end
    foreach (byte_tokens[i]) begin
      r = byte_tokens[i];
      r.last = (i == byte_tokens.size() - 1);
      want_tokens = {want_tokens, r};
    end
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("token %0d: %s expected %0d got %0d", tokens_seen, what, want, got);
  endtask

  // caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] c, logic has, logic eos);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ch            <= c;
    has_char      <= has;
    end_of_source <= eos;
    src_valid     <= 1'b1;
    do @(posedge clk); while (src_stall !== 1'b0);
    predict_tokens(c, has, eos);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_byte(logic [7:0] b);
    src_bytes = {src_bytes, b};
  endfunction

  function automatic void add_digits(int n);
    repeat (n) add_byte(pick("0123456789"));
  endfunction

  function automatic void add_exponent();
    if ($urandom_range(0, 1)) begin
      add_byte(pick("Ee"));
      if ($urandom_range(0, 1)) add_byte(pick("+-"));
      add_digits($urandom_range(0, 2));
    end
  endfunction

  // one well-formed token, a separator, or noise
  function automatic void add_fragment();
    int n;
    n = $urandom_range(0, 4);
    case ($urandom_range(0, 11))
      0: begin
        add_byte(pick("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz"));
        repeat (n) add_byte(pick("AZaz09_$qM7"));
      end
      1: add_digits(n + 1);
      2: begin
        add_digits(n + 1);
        add_byte(C_DOT);
        add_digits($urandom_range(0, 3));
        add_exponent();
      end
      3: begin
        add_byte(C_DOT);
        add_digits(n + 1);
        if ($urandom_range(0, 1)) begin
          add_byte(C_DOT);
          add_digits($urandom_range(0, 2));
        end
        add_exponent();
      end
      4: begin
        add_byte(C_DOLLAR);
        repeat (n + 1) add_byte(pick("0123456789ABCDEFabcdef"));
      end
      5: begin
        add_byte(C_QUOTE);
        repeat (n) add_byte(pick("ab 1$.:<>=+\t_Z~"));
        case ($urandom_range(0, 3))
          0: add_byte(C_NL);
          1: ;
          default: add_byte(C_QUOTE);
        endcase
      end
      6: begin
        case ($urandom_range(0, 3))
          0: begin add_byte(C_COLON); add_byte(C_EQ); end
          1: begin add_byte(C_LT); add_byte(C_GT); end
          2: begin add_byte(C_LT); add_byte(C_EQ); end
          default: begin add_byte(C_GT); add_byte(C_EQ); end
        endcase
      end
      7: add_byte(pick("$.:<>"));
      8: add_byte(pick("+-*/(),;=#&!?@[]^{}|~'%"));
      9: begin
        case ($urandom_range(0, 2))
          0: add_byte(C_SPACE);
          1: add_byte(C_TAB);
          default: add_byte(C_CR);
        endcase
      end
      10: add_byte(C_NL);
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic test_directed();
    send_text("\"a\"\"b");
    send_byte(C_NL, 1'b1, 1'b0);
    send_text("$F$g:=.5.5e-<><=>=9E");
    send_byte(C_TAB, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_text(".x>");
    send_byte(8'h00, 1'b0, 1'b0);
    send_text(" .");
    send_byte(8'hFF, 1'b0, 1'b1);
    // open string cut by a newline on the end request: three tokens at once
    send_text("\"");
    send_byte(C_NL, 1'b1, 1'b1);
  endtask

  task automatic test_random();
    int items;
    int end_mode;
    items = 0;
    while (items < 200) begin
      src_bytes.delete();
      repeat ($urandom_range(1, 8)) add_fragment();
      if ($urandom_range(0, 3) == 0) begin
        src_gap_max    = 0;
        sink_stall_max = 0;
      end else begin
        src_gap_max    = 7;
        sink_stall_max = 7;
      end
      end_mode = $urandom_range(0, 3);
      foreach (src_bytes[i]) begin
        if ($urandom_range(0, 19) == 0)
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_byte(src_bytes[i], 1'b1, end_mode == 0 && i == src_bytes.size() - 1);
        items++;
      end
      if (end_mode == 1) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        items++;
      end
    end
    src_gap_max    = 7;
    sink_stall_max = 7;
  endtask

  // receiver holds off while requests keep coming, so the queue fills
  task automatic test_pressure();
    src_gap_max = 0;
    sink_hold   = 300;
    repeat (40) begin
      send_byte(pick("+-*/"), 1'b1, 1'b0);
      send_byte(C_NL, 1'b1, 1'b0);
    end
    send_byte("z", 1'b1, 1'b1);
    src_gap_max = 7;
  endtask

  // token receiver
  initial begin
    int n;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      n = $urandom_range(0, sink_stall_max);
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
      end
      if (n > 0) begin
        tok_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      tok_stall <= 1'b0;
      do @(posedge clk); while (tok_valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : token_check
    tok_rec_t want;
    if (!rst) begin
      if (tok_valid === 1'b1 && tok_stall === 1'b0) begin
        if (want_tokens.size() == 0) begin
          report_mismatch("unexpected token, kind", 16'd0, 16'(token_kind));
        end else begin
          want = want_tokens.pop_front();
          if (token_kind !== want.kind)     report_mismatch("kind", want.kind, token_kind);
          if (start_offset !== want.offset) report_mismatch("offset", want.offset, start_offset);
          if (token_length !== want.length) report_mismatch("length", want.length, token_length);
          if (start_line !== want.line)     report_mismatch("line", want.line, start_line);
          if (start_column !== want.column) report_mismatch("column", want.column, start_column);
          if (last !== want.last)           report_mismatch("last", want.last, last);
        end
        tokens_seen++;
      end
      if ((src_valid === 1'b1 && src_stall === 1'b0) ||
          (tok_valid === 1'b1 && tok_stall === 1'b0))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    lex_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random();
    test_pressure();
    src_valid <= 1'b0;
    while (want_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
